### src/assert_macros.svh
// Assertion macros shared by the vertex generator RTL.
// Standalone header; it depends on nothing else.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
// Clocked assertion that is switched off while reset is asserted.
`define RPSV_ASSERT(lbl, clk, rst_n, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
// Clocked assertion that is checked during reset as well.
`define RPSV_ASSERT_ALWAYS(lbl, clk, prop, msg) \
	lbl: assert property (@(posedge clk) prop) else $error(msg);
`else
`define RPSV_ASSERT(lbl, clk, rst_n, prop, msg)
`define RPSV_ASSERT_ALWAYS(lbl, clk, prop, msg)
`endif
`endif

### src/rpsv_pkg.sv
// Shared types, constants and the sine/cosine table builder for the vertex generator.
// Used by the front end, the descriptor queue, the vertex engine and the top level.
package rpsv_pkg;

	localparam int SIDES_W   = 5;
	localparam int START_W   = 9;
	localparam int RADIUS_W  = 12;
	localparam int COORD_W   = 16;
	localparam int TRIG_W    = 16;
	localparam int ANGLE_W   = 12;
	localparam int CNT_W     = 6;

	localparam int CFG_IDX_W  = 1;
	localparam int CFG_DATA_W = 9;
	localparam logic [CFG_IDX_W-1:0] REG_NUM_SIDES   = 1'b0;
	localparam logic [CFG_IDX_W-1:0] REG_START_ANGLE = 1'b1;

	localparam logic [SIDES_W-1:0] NUM_SIDES_RESET = 5'd5;
	localparam int MIN_SIDES       = 3;
	localparam int MAX_STAR_POINTS = 16;

	localparam logic FUNC_POLYGON = 1'b0;
	localparam logic FUNC_STAR    = 1'b1;

	localparam int CORDIC_ITERS = 16;
	localparam logic signed [63:0] CORDIC_GAIN_START = 64'sd652032874;
	localparam logic [31:0] ATAN_TURN [CORDIC_ITERS] = '{
		32'd536870912, 32'd316933406, 32'd167458907, 32'd85004756,
		32'd42667331,  32'd21354465,  32'd10679838,  32'd5340245,
		32'd2670163,   32'd1335087,   32'd667544,    32'd333772,
		32'd166886,    32'd83443,     32'd41722,     32'd20861
	};

	// One shape request as it travels from the front end to the vertex engine.
	typedef struct packed {
		logic                       func;
		logic [RADIUS_W-1:0]        radius;
		logic signed [COORD_W-1:0]  center_x;
		logic signed [COORD_W-1:0]  center_y;
		logic [CNT_W-1:0]           count;
		logic [ANGLE_W-1:0]         step;
		logic [ANGLE_W-1:0]         start;
	} desc_t;

	// Builds one table entry {cos, sin} in Q1.15 from a 32-bit fraction of a turn.
	// It runs at elaboration only, to fill the constant table.
	function automatic logic [2*TRIG_W-1:0] trig_entry(input logic [31:0] phase);
		logic signed [63:0] x;
		logic signed [63:0] y;
		logic signed [63:0] z;
		logic signed [63:0] dx;
		logic signed [63:0] dy;
		logic signed [63:0] cr;
		logic signed [63:0] sr;
		logic signed [TRIG_W-1:0] c;
		logic signed [TRIG_W-1:0] s;
		logic signed [TRIG_W-1:0] co;
		logic signed [TRIG_W-1:0] so;
		logic [1:0] quad;
		quad = phase[31:30];
		x = CORDIC_GAIN_START;
		y = '0;
		z = $signed({34'd0, phase[29:0]});
		for (int i = 0; i < CORDIC_ITERS; i++) begin
			dx = y >>> i;
			dy = x >>> i;
			if (z >= 0) begin
				x = x - dx;
				y = y + dy;
				z = z - $signed({32'd0, ATAN_TURN[i]});
			end else begin
				x = x + dx;
				y = y - dy;
				z = z + $signed({32'd0, ATAN_TURN[i]});
			end
		end
		cr = (x + 64'sd16384) >>> 15;
		sr = (y + 64'sd16384) >>> 15;
		if (cr < 0) cr = '0;
		if (cr > 64'sd32767) cr = 64'sd32767;
		if (sr < 0) sr = '0;
		if (sr > 64'sd32767) sr = 64'sd32767;
		c = TRIG_W'(cr);
		s = TRIG_W'(sr);
		case (quad)
			2'd0: begin
				co = c;
				so = s;
			end
			2'd1: begin
				co = -s;
				so = c;
			end
			2'd2: begin
				co = -c;
				so = -s;
			end
			default: begin
				co = s;
				so = -c;
			end
		endcase
		return {co, so};
	endfunction

endpackage

### src/rpsv_front.sv
// Front end: configuration registers, request intake, side clamping, the start
// angle wrap and the iterative divider that derives the angle step.
// Depends on rpsv_pkg and assert_macros.svh.
`include "assert_macros.svh"

module rpsv_front
	import rpsv_pkg::*;
#(
	parameter int ANGLE_STEPS = 360,
	parameter int MAX_SIDES   = 16
) (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       cfg_valid,
	output logic                       cfg_ready,
	input  logic [CFG_IDX_W-1:0]       cfg_index,
	input  logic [CFG_DATA_W-1:0]      cfg_data,
	input  logic                       in_valid,
	output logic                       in_ready,
	input  logic                       func,
	input  logic [RADIUS_W-1:0]        radius,
	input  logic signed [COORD_W-1:0]  center_x,
	input  logic signed [COORD_W-1:0]  center_y,
	output logic                       push,
	output desc_t                      push_desc,
	input  logic                       q_full
);

	localparam int AS_W  = $clog2(ANGLE_STEPS + 1);
	localparam int DV_W  = (AS_W > START_W) ? AS_W : START_W;
	localparam int ITR_W = $clog2(DV_W);
	localparam logic [DV_W-1:0]  AS_DV    = DV_W'(ANGLE_STEPS);
	localparam logic [ITR_W-1:0] ITR_LAST = ITR_W'(DV_W - 1);

	localparam logic [1:0] ST_IDLE = 2'd0;
	localparam logic [1:0] ST_DIV  = 2'd1;
	localparam logic [1:0] ST_PUSH = 2'd2;

	logic [SIDES_W-1:0] num_sides_q;
	logic [START_W-1:0] start_angle_q;

	logic [1:0]       state_q;
	logic [ITR_W-1:0] itr_q;

	logic [DV_W-1:0] dvd_q;
	logic [DV_W-1:0] dsor_q;
	logic [DV_W-1:0] rem_q;
	logic [DV_W-1:0] quo_q;

	logic                      func_q;
	logic [RADIUS_W-1:0]       radius_q;
	logic signed [COORD_W-1:0] center_x_q;
	logic signed [COORD_W-1:0] center_y_q;
	logic [SIDES_W-1:0]        sides_q;
	logic [ANGLE_W-1:0]        step_q;
	logic [ANGLE_W-1:0]        start_q;

	logic               accept;
	logic [SIDES_W-1:0] n_c;
	logic [DV_W:0]      rem_sh;
	logic               ge;
	logic [DV_W:0]      rem_nx;
	logic [DV_W-1:0]    quo_nx;
	logic [DV_W-1:0]    step_raw;
	logic [DV_W-1:0]    start_wrap;

	assign cfg_ready = 1'b1;
	assign in_ready  = (state_q == ST_IDLE);
	assign accept    = in_valid && in_ready;

	// Clamp the side count into the supported range; a star has at most 16 points.
	always_comb begin
		n_c = num_sides_q;
		if (num_sides_q < SIDES_W'(MIN_SIDES)) begin
			n_c = SIDES_W'(MIN_SIDES);
		end else if ({1'b0, num_sides_q} > (SIDES_W+1)'(MAX_SIDES)) begin
			n_c = SIDES_W'(MAX_SIDES);
		end
		if (func == FUNC_STAR && n_c > SIDES_W'(MAX_STAR_POINTS)) begin
			n_c = SIDES_W'(MAX_STAR_POINTS);
		end
	end

	// Wrap the start angle by subtracting shifted copies of the turn length,
	// largest first; only the shifts that fit below the register range take part.
	always_comb begin
		start_wrap = DV_W'(start_angle_q);
		for (int k = START_W - 1; k >= 0; k--) begin
			if ((ANGLE_STEPS << k) < (1 << START_W)
					&& start_wrap >= DV_W'(ANGLE_STEPS << k)) begin
				start_wrap = start_wrap - DV_W'(ANGLE_STEPS << k);
			end
		end
	end

	// One restoring division step per cycle.
	assign rem_sh   = {rem_q, dvd_q[DV_W-1]};
	assign ge       = (rem_sh >= {1'b0, dsor_q});
	assign rem_nx   = ge ? (rem_sh - {1'b0, dsor_q}) : rem_sh;
	assign quo_nx   = {quo_q[DV_W-2:0], ge};
	assign step_raw = (func_q == FUNC_STAR) ? (quo_nx >> 1) : quo_nx;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			num_sides_q   <= NUM_SIDES_RESET;
			start_angle_q <= '0;
		end else if (cfg_valid && cfg_ready) begin
			if (cfg_index == REG_NUM_SIDES) begin
				num_sides_q <= cfg_data[SIDES_W-1:0];
			end else if (cfg_index == REG_START_ANGLE) begin
				start_angle_q <= cfg_data[START_W-1:0];
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			itr_q   <= '0;
		end else begin
			case (state_q)
				ST_IDLE: begin
					if (accept) begin
						state_q <= ST_DIV;
						itr_q   <= ITR_LAST;
					end
				end
				ST_DIV: begin
					itr_q <= itr_q - 1'b1;
					if (itr_q == '0) begin
						state_q <= ST_PUSH;
					end
				end
				ST_PUSH: begin
					if (!q_full) begin
						state_q <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			func_q     <= func;
			radius_q   <= radius;
			center_x_q <= center_x;
			center_y_q <= center_y;
			sides_q    <= n_c;
			start_q    <= ANGLE_W'(start_wrap);
			dvd_q      <= AS_DV;
			dsor_q     <= DV_W'(n_c);
			rem_q      <= '0;
			quo_q      <= '0;
		end else if (state_q == ST_DIV) begin
			dvd_q <= dvd_q << 1;
			rem_q <= rem_nx[DV_W-1:0];
			quo_q <= quo_nx;
			if (itr_q == '0) begin
				step_q <= ANGLE_W'(step_raw);
			end
		end
	end

	assign push = (state_q == ST_PUSH) && !q_full;

	always_comb begin
		push_desc          = '0;
		push_desc.func     = func_q;
		push_desc.radius   = radius_q;
		push_desc.center_x = center_x_q;
		push_desc.center_y = center_y_q;
		push_desc.count    = (func_q == FUNC_STAR) ? {sides_q, 1'b0} : {1'b0, sides_q};
		push_desc.step     = step_q;
		push_desc.start    = start_q;
	end

	`RPSV_ASSERT(a_div_nonzero, clk, arst_n, (state_q == ST_DIV |-> dsor_q != '0), "divider runs with a zero divisor")

endmodule

### src/rpsv_queue.sv
// Two-entry descriptor queue between the front end and the vertex engine.
// Depends on rpsv_pkg and assert_macros.svh.
`include "assert_macros.svh"

module rpsv_queue
	import rpsv_pkg::*;
(
	input  logic  clk,
	input  logic  arst_n,
	input  logic  push,
	input  desc_t push_desc,
	output logic  full,
	input  logic  pop,
	output desc_t pop_desc,
	output logic  empty
);

	desc_t      mem_q [2];
	logic       wr_ptr_q;
	logic       rd_ptr_q;
	logic [1:0] cnt_q;

	assign full     = (cnt_q == 2'd2);
	assign empty    = (cnt_q == 2'd0);
	assign pop_desc = mem_q[rd_ptr_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= 1'b0;
			rd_ptr_q <= 1'b0;
			cnt_q    <= 2'd0;
		end else begin
			if (push) begin
				wr_ptr_q <= ~wr_ptr_q;
			end
			if (pop) begin
				rd_ptr_q <= ~rd_ptr_q;
			end
			if (push && !pop) begin
				cnt_q <= cnt_q + 2'd1;
			end else if (pop && !push) begin
				cnt_q <= cnt_q - 2'd1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_ptr_q] <= push_desc;
		end
	end

	`RPSV_ASSERT(a_no_overflow, clk, arst_n, (!(push && full)), "push into a full descriptor queue")
	`RPSV_ASSERT(a_no_underflow, clk, arst_n, (!(pop && empty)), "pop from an empty descriptor queue")

endmodule

### src/rpsv_back.sv
// Vertex engine: walks the angles of one descriptor, reads the sine/cosine
// table, scales by the radius, adds the center and saturates. Depends on rpsv_pkg and assert_macros.svh.
`include "assert_macros.svh"

module rpsv_back
	import rpsv_pkg::*;
#(
	parameter int ANGLE_STEPS = 360
) (
	input  logic                       clk,
	input  logic                       arst_n,
	input  desc_t                      pop_desc,
	input  logic                       q_empty,
	output logic                       pop,
	output logic                       out_valid,
	input  logic                       out_ready,
	output logic signed [COORD_W-1:0]  vertex_x,
	output logic signed [COORD_W-1:0]  vertex_y,
	output logic                       last
);

	localparam int AIW  = $clog2(ANGLE_STEPS);
	localparam int PR_W = RADIUS_W + 1 + TRIG_W;

	logic [2*TRIG_W-1:0] trig_rom [ANGLE_STEPS];

	for (genvar g = 0; g < ANGLE_STEPS; g++) begin : g_rom
		localparam logic [63:0] PHASE = (64'(g) << 32) / ANGLE_STEPS;
		localparam logic [2*TRIG_W-1:0] ENTRY = trig_entry(PHASE[31:0]);
		assign trig_rom[g] = ENTRY;
	end

	desc_t              cur_q;
	logic               active_q;
	logic [ANGLE_W-1:0] angle_q;
	logic [CNT_W-1:0]   idx_q;

	logic                      vld_s1;
	logic [2*TRIG_W-1:0]       trig_s1;
	logic [RADIUS_W-1:0]       rad_s1;
	logic signed [COORD_W-1:0] cx_s1;
	logic signed [COORD_W-1:0] cy_s1;
	logic                      last_s1;

	logic                      vld_s2;
	logic signed [PR_W-1:0]    px_s2;
	logic signed [PR_W-1:0]    py_s2;
	logic signed [COORD_W-1:0] cx_s2;
	logic signed [COORD_W-1:0] cy_s2;
	logic                      last_s2;

	logic                      out_valid_q;
	logic signed [COORD_W-1:0] vertex_x_q;
	logic signed [COORD_W-1:0] vertex_y_q;
	logic                      last_q;

	logic                  en;
	logic                  issue;
	logic                  last_iss;
	logic [RADIUS_W-1:0]   rad_iss;
	logic [ANGLE_W:0]      angle_sum;
	logic [ANGLE_W-1:0]    angle_nx;
	logic signed [PR_W-1:0] px;
	logic signed [PR_W-1:0] py;

	// Truncating divide by 2^15, add the center, saturate to 16 bits.
	function automatic logic signed [COORD_W-1:0] place(
		input logic signed [PR_W-1:0]    prod,
		input logic signed [COORD_W-1:0] center
	);
		logic signed [PR_W-1:0]    t;
		logic signed [COORD_W:0]   sum;
		logic signed [COORD_W-1:0] res;
		t   = prod + (prod[PR_W-1] ? PR_W'(32767) : PR_W'(0));
		sum = (COORD_W+1)'(t >>> 15) + (COORD_W+1)'(center);
		if (sum[COORD_W] != sum[COORD_W-1]) begin
			res = sum[COORD_W] ? {1'b1, {(COORD_W-1){1'b0}}} : {1'b0, {(COORD_W-1){1'b1}}};
		end else begin
			res = sum[COORD_W-1:0];
		end
		return res;
	endfunction

	// The whole pipeline advances together whenever the output register is free.
	assign en       = !out_valid_q || out_ready;
	assign issue    = active_q && en;
	assign pop      = !active_q && !q_empty;
	assign last_iss = (idx_q == cur_q.count - 1'b1);
	assign rad_iss  = (cur_q.func == FUNC_STAR && idx_q[0]) ? {1'b0, cur_q.radius[RADIUS_W-1:1]}
	                                                       : cur_q.radius;
	assign angle_sum = {1'b0, angle_q} + {1'b0, cur_q.step};
	assign angle_nx  = (angle_sum >= (ANGLE_W+1)'(ANGLE_STEPS))
	                 ? ANGLE_W'(angle_sum - (ANGLE_W+1)'(ANGLE_STEPS)) : angle_sum[ANGLE_W-1:0];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			active_q <= 1'b0;
		end else if (pop) begin
			active_q <= 1'b1;
		end else if (issue && last_iss) begin
			active_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (pop) begin
			cur_q   <= pop_desc;
			angle_q <= pop_desc.start;
			idx_q   <= '0;
		end else if (issue) begin
			angle_q <= angle_nx;
			idx_q   <= idx_q + 1'b1;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1      <= 1'b0;
			vld_s2      <= 1'b0;
			out_valid_q <= 1'b0;
		end else if (en) begin
			vld_s1      <= issue;
			vld_s2      <= vld_s1;
			out_valid_q <= vld_s2;
		end
	end

	assign px = $signed({1'b0, rad_s1}) * $signed(trig_s1[2*TRIG_W-1:TRIG_W]);
	assign py = $signed({1'b0, rad_s1}) * $signed(trig_s1[TRIG_W-1:0]);

	always_ff @(posedge clk) begin
		if (en) begin
			trig_s1 <= trig_rom[angle_q[AIW-1:0]];
			rad_s1  <= rad_iss;
			cx_s1   <= cur_q.center_x;
			cy_s1   <= cur_q.center_y;
			last_s1 <= last_iss;

			px_s2   <= px;
			py_s2   <= py;
			cx_s2   <= cx_s1;
			cy_s2   <= cy_s1;
			last_s2 <= last_s1;

			if (vld_s2) begin
				vertex_x_q <= place(px_s2, cx_s2);
				vertex_y_q <= place(py_s2, cy_s2);
				last_q     <= last_s2;
			end
		end
	end

	assign out_valid = out_valid_q;
	assign vertex_x  = vertex_x_q;
	assign vertex_y  = vertex_y_q;
	assign last      = last_q;

	`RPSV_ASSERT(a_idx_in_range, clk, arst_n, (active_q |-> idx_q < cur_q.count), "vertex index ran past the vertex count")
	`RPSV_ASSERT(a_angle_wrapped, clk, arst_n, (active_q |-> ({1'b0, angle_q} < (ANGLE_W+1)'(ANGLE_STEPS))), "angle left the table range")
	`RPSV_ASSERT(a_pop_idle, clk, arst_n, (pop |=> active_q), "descriptor popped but the engine did not start")

endmodule

### src/regular_polygon_star_vertex_gen.sv
// Regular polygon and star vertex generator, top level.
// Depends on rpsv_pkg, rpsv_front, rpsv_queue and rpsv_back.
//
// The cfg channel (cfg_valid/cfg_ready, cfg_index, cfg_data) writes num_sides
// (index 0) and start_angle (index 1); it is always ready. The user must see
// that it is written only while no request is in flight; the block does not
// enforce this. The in channel takes one request (func, radius, center); the
// out channel returns its vertices in order, n for a polygon and 2n for a star,
// with last set on the final one. The front end derives the angle step in a
// one-bit-per-cycle divider DV bits wide (DV = max(clog2(ANGLE_STEPS+1), 9), so
// 9 at 360 steps), then hands the descriptor to the queue, waiting while it is
// full, and takes a new request only after that hand-over. The vertex engine
// pops a descriptor when idle and the queue is not empty, then issues one vertex
// per cycle unless the output stalls, through a three-stage table/multiply/
// place pipeline. A two-entry queue between the parts lets the next request be
// divided while vertices are still leaving. When out_ready is low the engine
// pipeline holds; the queue and front end fill up and then in_ready drops.
// Reset clears all control state and sets num_sides to 5 and start_angle to 0.
module regular_polygon_star_vertex_gen
	import rpsv_pkg::*;
#(
	parameter int ANGLE_STEPS = 360,
	parameter int MAX_SIDES   = 16
) (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       cfg_valid,
	output logic                       cfg_ready,
	input  logic [CFG_IDX_W-1:0]       cfg_index,
	input  logic [CFG_DATA_W-1:0]      cfg_data,
	input  logic                       in_valid,
	output logic                       in_ready,
	input  logic                       func,
	input  logic [RADIUS_W-1:0]        radius,
	input  logic signed [COORD_W-1:0]  center_x,
	input  logic signed [COORD_W-1:0]  center_y,
	output logic                       out_valid,
	input  logic                       out_ready,
	output logic signed [COORD_W-1:0]  vertex_x,
	output logic signed [COORD_W-1:0]  vertex_y,
	output logic                       last
);

	logic  push;
	desc_t push_desc;
	logic  q_full;
	logic  pop;
	desc_t pop_desc;
	logic  q_empty;

	rpsv_front #(
		.ANGLE_STEPS (ANGLE_STEPS),
		.MAX_SIDES   (MAX_SIDES)
	) u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.func      (func),
		.radius    (radius),
		.center_x  (center_x),
		.center_y  (center_y),
		.push      (push),
		.push_desc (push_desc),
		.q_full    (q_full)
	);

	rpsv_queue u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.push_desc (push_desc),
		.full      (q_full),
		.pop       (pop),
		.pop_desc  (pop_desc),
		.empty     (q_empty)
	);

	rpsv_back #(
		.ANGLE_STEPS (ANGLE_STEPS)
	) u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.pop_desc  (pop_desc),
		.q_empty   (q_empty),
		.pop       (pop),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.vertex_x  (vertex_x),
		.vertex_y  (vertex_y),
		.last      (last)
	);

endmodule

### bench/regular_polygon_star_vertex_gen_tb.sv
// Self-checking bench for the polygon and star vertex generator.
// It depends on rpsv_pkg and the regular_polygon_star_vertex_gen RTL only.
// A built-in CORDIC predictor supplies the expected vertex stream per shape request.
module regular_polygon_star_vertex_gen_tb;
	import rpsv_pkg::*;

	localparam int STEPS_PER_TURN = 360;
	localparam int SIDES_LIMIT    = 16;
	localparam int STAR_LIMIT     = 16;
	localparam int LONG_HOLD      = 300;
	localparam int QUIET_CYCLES   = 40;

	typedef enum {TRAFFIC_RANDOM, TRAFFIC_FULL, TRAFFIC_RECV_HOLD} traffic_t;

	typedef struct {
		logic                      func;
		logic [RADIUS_W-1:0]       radius;
		logic signed [COORD_W-1:0] cx;
		logic signed [COORD_W-1:0] cy;
	} shape_req_t;

	typedef struct {
		logic signed [COORD_W-1:0] x;
		logic signed [COORD_W-1:0] y;
		logic                      last;
	} vertex_t;

	// Arctangent of 2^-i, in units of 2^-32 turn.
	localparam longint ARCTAN_LUT [16] = '{
		536870912, 316933406, 167458907, 85004756,
		42667331, 21354465, 10679838, 5340245,
		2670163, 1335087, 667544, 333772,
		166886, 83443, 41722, 20861
	};
	localparam longint CORDIC_X0 = 652032874;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic cfg_valid = 1'b0;
	logic cfg_ready;
	logic [CFG_IDX_W-1:0] cfg_index = '0;
	logic [CFG_DATA_W-1:0] cfg_data = '0;
	logic in_valid = 1'b0;
	logic in_ready;
	logic func = 1'b0;
	logic [RADIUS_W-1:0] radius = '0;
	logic signed [COORD_W-1:0] center_x = '0;
	logic signed [COORD_W-1:0] center_y = '0;
	logic out_valid;
	logic out_ready = 1'b0;
	logic signed [COORD_W-1:0] vertex_x;
	logic signed [COORD_W-1:0] vertex_y;
	logic last;

	shape_req_t pending_shapes[$];
	vertex_t expected_vertices[$];
	logic [SIDES_W-1:0] sides_reg = 5'd5;
	logic [START_W-1:0] start_reg = '0;
	bit full_rate = 1'b0;
	bit recv_hold = 1'b0;
	int send_gap = 0;
	int recv_wait = 0;
	int err_count = 0;

	regular_polygon_star_vertex_gen #(
		.ANGLE_STEPS(STEPS_PER_TURN),
		.MAX_SIDES(SIDES_LIMIT)
	) dut (
		.clk(clk),
		.arst_n(arst_n),
		.cfg_valid(cfg_valid),
		.cfg_ready(cfg_ready),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data),
		.in_valid(in_valid),
		.in_ready(in_ready),
		.func(func),
		.radius(radius),
		.center_x(center_x),
		.center_y(center_y),
		.out_valid(out_valid),
		.out_ready(out_ready),
		.vertex_x(vertex_x),
		.vertex_y(vertex_y),
		.last(last)
	);

	always #4 clk = ~clk;

	function automatic int round_q15(input longint v);
		longint r;
		r = (v + 64'sd16384) >>> 15;
		if (r < 0) r = 0;
		if (r > 32767) r = 32767;
		return int'(r);
	endfunction

	// Cosine and sine in Q1.15 for an angle given in angle steps.
	function automatic void cordic_cos_sin(input int unsigned ang, output int cs, output int sn);
		longint unsigned phase;
		longint x;
		longint y;
		longint z;
		longint dx;
		longint dy;
		int c;
		int s;
		logic [1:0] quad;
		phase = (longint'(ang) << 32) / STEPS_PER_TURN;
		quad = phase[31:30];
		x = CORDIC_X0;
		y = 0;
		z = longint'(phase[29:0]);
		for (int i = 0; i < 16; i++) begin
			dx = y >>> i;
			dy = x >>> i;
			if (z >= 0) begin
				x = x - dx;
				y = y + dy;
				z = z - ARCTAN_LUT[i];
			end else begin
				x = x + dx;
				y = y - dy;
				z = z + ARCTAN_LUT[i];
			end
		end
		c = round_q15(x);
		s = round_q15(y);
		case (quad)
			2'd0: begin cs = c; sn = s; end
			2'd1: begin cs = -s; sn = c; end
			2'd2: begin cs = -c; sn = -s; end
			default: begin cs = s; sn = -c; end
		endcase
	endfunction

	function automatic logic signed [COORD_W-1:0] place_coord(input int rad, input int tv,
			input int center);
		int v;
		// The product is truncated toward zero before the center is added.
		v = (rad * tv) / 32768 + center;
		if (v > 32767) v = 32767;
		if (v < -32768) v = -32768;
		return v[COORD_W-1:0];
	endfunction

	// Queues the vertices that one accepted shape request must produce.
	task automatic predict_vertices(input logic star, input int rad_in, input int cx, input int cy);
		int n;
		int step;
		int count;
		int ang;
		int rad;
		int cs;
		int sn;
		vertex_t v;
		n = sides_reg;
		if (n < 3) n = 3;
		if (n > SIDES_LIMIT) n = SIDES_LIMIT;
		if (star == FUNC_STAR && n > STAR_LIMIT) n = STAR_LIMIT;
		step = STEPS_PER_TURN / n;
		if (star == FUNC_STAR) step = step / 2;
		step = step % STEPS_PER_TURN;
		count = (star == FUNC_STAR) ? 2 * n : n;
		ang = start_reg % STEPS_PER_TURN;
		for (int i = 0; i < count; i++) begin
			// Odd star vertices sit on the inner radius.
			rad = (star == FUNC_STAR && i % 2 == 1) ? (rad_in >> 1) : rad_in;
			cordic_cos_sin(ang, cs, sn);
			v.x = place_coord(rad, cs, cx);
			v.y = place_coord(rad, sn, cy);
			v.last = (i + 1 == count);
			expected_vertices = {expected_vertices, v};
			ang = (ang + step) % STEPS_PER_TURN;
		end
	endtask

	// Appends one shape request to the driver's queue.
	task automatic queue_shape(input shape_req_t s);
		pending_shapes = {pending_shapes, s};
	endtask

	function automatic int draw_wait();
		if (full_rate || $urandom_range(0, 1) == 0) return 0;
		return $urandom_range(1, 12);
	endfunction

	function automatic logic signed [COORD_W-1:0] random_center();
		case ($urandom_range(0, 5))
			0: return 16'h7FFF;
			1: return 16'h8000;
			2: return COORD_W'($urandom_range(0, 64) - 32);
			default: return COORD_W'($urandom);
		endcase
	endfunction

	function automatic shape_req_t random_shape();
		shape_req_t r;
		r.func = $urandom_range(0, 1) ? FUNC_STAR : FUNC_POLYGON;
		case ($urandom_range(0, 5))
			0: r.radius = '0;
			1: r.radius = '1;
			2: r.radius = RADIUS_W'($urandom_range(0, 15));
			default: r.radius = RADIUS_W'($urandom);
		endcase
		r.cx = random_center();
		r.cy = random_center();
		return r;
	endfunction

	task automatic report_mismatch(input string msg);
		if (err_count < 40) $display("ERROR @%0t: %s", $time, msg);
		err_count++;
	endtask

	// Request driver: presents queued shapes and predicts each accepted transaction.
	always @(posedge clk or negedge arst_n) begin
		shape_req_t r;
		if (!arst_n) begin
			in_valid <= 1'b0;
			send_gap <= 0;
		end else begin
			if (in_valid && in_ready)
				predict_vertices(func, int'(radius), int'(center_x), int'(center_y));
			if (!in_valid || in_ready) begin
				if (send_gap != 0) begin
					send_gap <= send_gap - 1;
					in_valid <= 1'b0;
				end else if (pending_shapes.size() != 0) begin
					r = pending_shapes.pop_front();
					func <= r.func;
					radius <= r.radius;
					center_x <= r.cx;
					center_y <= r.cy;
					in_valid <= 1'b1;
					send_gap <= draw_wait();
				end else begin
					in_valid <= 1'b0;
				end
			end
		end
	end

	// Vertex monitor: checks each output transaction and paces out_ready.
	always @(posedge clk or negedge arst_n) begin
		vertex_t v;
		int w;
		if (!arst_n) begin
			out_ready <= 1'b0;
			recv_wait <= 0;
		end else begin
			if (out_valid && out_ready) begin
				if (expected_vertices.size() == 0) begin
					report_mismatch($sformatf("unexpected vertex (%0d, %0d)", vertex_x, vertex_y));
				end else begin
					v = expected_vertices.pop_front();
					if (vertex_x !== v.x)
						report_mismatch($sformatf("vertex_x %0d, expected %0d", vertex_x, v.x));
					if (vertex_y !== v.y)
						report_mismatch($sformatf("vertex_y %0d, expected %0d", vertex_y, v.y));
					if (last !== v.last)
						report_mismatch($sformatf("last %b, expected %b", last, v.last));
				end
				w = draw_wait();
				recv_wait <= w;
				out_ready <= (w == 0) && !recv_hold;
			end else if (recv_wait != 0) begin
				recv_wait <= recv_wait - 1;
				out_ready <= (recv_wait == 1) && !recv_hold;
			end else begin
				out_ready <= !recv_hold;
			end
		end
	end

	task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] data);
		@(posedge clk);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data <= data;
		do @(negedge clk); while (!cfg_ready);
		@(posedge clk);
		if (idx == REG_NUM_SIDES)
			sides_reg = data[SIDES_W-1:0];
		else
			start_reg = data[START_W-1:0];
		cfg_valid <= 1'b0;
	endtask

	// Waits until every queued shape has been sent and all its vertices have come back.
	task automatic drain();
		do @(negedge clk);
		while (pending_shapes.size() != 0 || in_valid || expected_vertices.size() != 0);
		repeat (QUIET_CYCLES) @(negedge clk);
	endtask

	task automatic run_phase(input int sides, input int start, input int items, input traffic_t mode);
		write_reg(REG_NUM_SIDES, CFG_DATA_W'(sides));
		write_reg(REG_START_ANGLE, CFG_DATA_W'(start));
		@(negedge clk);
		full_rate = (mode != TRAFFIC_RANDOM);
		recv_hold = (mode == TRAFFIC_RECV_HOLD);
		repeat (items) queue_shape(random_shape());
		// Holding the receiver off lets the engine back up until in_ready drops.
		if (mode == TRAFFIC_RECV_HOLD) begin
			repeat (LONG_HOLD) @(negedge clk);
			recv_hold = 1'b0;
		end
		drain();
	endtask

	initial begin
		repeat (8) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// Reset configuration: five sides starting at angle zero.
		queue_shape('{FUNC_POLYGON, 12'd0, 16'sd0, 16'sd0});
		queue_shape('{FUNC_STAR, 12'd0, 16'sd0, 16'sd0});
		queue_shape('{FUNC_POLYGON, 12'hFFF, 16'sd0, 16'sd0});
		queue_shape('{FUNC_STAR, 12'hFFF, 16'sd0, 16'sd0});
		queue_shape('{FUNC_POLYGON, 12'hFFF, 16'h7FFF, 16'h7FFF});
		queue_shape('{FUNC_STAR, 12'hFFF, 16'h8000, 16'h8000});
		queue_shape('{FUNC_POLYGON, 12'd1, 16'hFFFF, 16'sd1});
		queue_shape('{FUNC_STAR, 12'd1, 16'sd0, 16'sd0});
		queue_shape('{FUNC_POLYGON, 12'hFFE, 16'h7FFF, 16'h8000});
		queue_shape('{FUNC_STAR, 12'd2048, 16'h8000, 16'h7FFF});
		drain();

		// Side counts below the minimum and above the maximum, and start angles past a turn.
		run_phase(0, 359, 30, TRAFFIC_RANDOM);
		run_phase(16, 360, 30, TRAFFIC_FULL);
		run_phase(31, 511, 30, TRAFFIC_RANDOM);
		run_phase(3, 0, 40, TRAFFIC_RECV_HOLD);
		run_phase(2, 180, 30, TRAFFIC_RANDOM);
		run_phase(17, 45, 30, TRAFFIC_RANDOM);
		repeat (7) run_phase($urandom_range(0, 31), $urandom_range(0, 511), 30, TRAFFIC_RANDOM);

		if (err_count == 0)
			$display("regular_polygon_star_vertex_gen_tb passed");
		else
			$display("regular_polygon_star_vertex_gen_tb failed");
		$finish;
	end

	initial begin
		#10000000;
		$display("regular_polygon_star_vertex_gen_tb failed");
		$finish;
	end

endmodule

### files.f
+incdir+src
src/rpsv_pkg.sv
src/rpsv_front.sv
src/rpsv_queue.sv
src/rpsv_back.sv
src/regular_polygon_star_vertex_gen.sv
bench/regular_polygon_star_vertex_gen_tb.sv
